/* hw/rtl/dmx_tx_pkg.sv */
// Shared constants for the DMX512 frame transmitter.
package dmx_tx_pkg;

    localparam int CHANNELS = 512;
    localparam int TBL_AW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam int CFG_IW = 3;
    localparam int CFG_DW = 10;

    // Register indexes
    localparam logic [CFG_IW-1:0] REG_BREAK     = 3'd0;
    localparam logic [CFG_IW-1:0] REG_MAB       = 3'd1;
    localparam logic [CFG_IW-1:0] REG_PRE_IDLE  = 3'd2;
    localparam logic [CFG_IW-1:0] REG_POST_IDLE = 3'd3;
    localparam logic [CFG_IW-1:0] REG_BIT_TIME  = 3'd4;
    localparam logic [CFG_IW-1:0] REG_SLOTS     = 3'd5;

    // Input operations
    localparam logic [1:0] OP_CHAR = 2'd0;
    localparam logic [1:0] OP_EOM  = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    // Frame phases
    localparam logic [2:0] PH_PRE   = 3'd0;
    localparam logic [2:0] PH_BREAK = 3'd1;
    localparam logic [2:0] PH_MAB   = 3'd2;
    localparam logic [2:0] PH_SLOTS = 3'd3;
    localparam logic [2:0] PH_POST  = 3'd4;

    // Command characters
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_COMMA = 8'h2C;

    localparam logic [9:0] CHAN_SAT  = 10'd1023;
    localparam logic [3:0] BITS_SLOT = 4'd11;

    localparam logic [9:0]  RST_BREAK     = 10'd120;
    localparam logic [9:0]  RST_MAB       = 10'd40;
    localparam logic [9:0]  RST_PRE_IDLE  = 10'd100;
    localparam logic [9:0]  RST_POST_IDLE = 10'd100;
    localparam logic [4:0]  RST_BIT_TIME  = 5'd4;
    localparam logic [9:0]  RST_SLOTS     = 10'd512;

endpackage

/* hw/rtl/dmx512_frame_transmitter.sv */
// DMX512 frame transmitter: command parser, channel table and frame sequencer.
//
// Input channel (i_in_valid/o_in_ready) carries one beat per operation: a command
// character, an end of message, or a one-microsecond tick. Every accepted beat
// gives exactly one result beat on the output channel (o_out_valid/i_out_ready):
// the serial line level, the frame phase and the slot number. A tick result shows
// the line during that tick; other operations report the line without advancing.
// The result of a beat is in the output register on the next cycle. One beat
// per cycle is sustained while the table is not being cleared; the output
// register is refilled in the same cycle it is drained, so a stalled receiver
// only holds the input side while its result is not taken.
// The 512-entry channel table is a single-port-write, registered-read RAM. A slot
// byte is read when the slot starts and taken from the RAM output on the next
// cycle. Commands commit a pair with one RAM write.
// After reset the table is cleared one entry per cycle, with o_in_ready low;
// configuration writes are taken during that time. Configuration is a plain write
// port (i_cfg_we, i_cfg_index, i_cfg_data) the user must use only while idle (unenforced).
module dmx512_frame_transmitter (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [dmx_tx_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [dmx_tx_pkg::CFG_DW-1:0] i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [1:0]                   i_op,
    input  logic [7:0]                   i_text_byte,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_line_level,
    output logic [2:0]                   o_frame_phase,
    output logic [9:0]                   o_slot_number
);
    import dmx_tx_pkg::*;

    localparam logic [9:0]        CH_MAX   = 10'(CHANNELS);
    localparam logic [TBL_AW-1:0] CLR_LAST = TBL_AW'(CHANNELS - 1);

    // configuration
    logic [9:0] r_break_time, r_mab_time, r_pre_idle, r_post_idle, r_slot_count;
    logic [4:0] r_bit_time;

    // channel table
    logic [7:0]        r_tbl [CHANNELS];
    logic [7:0]        r_tbl_q;
    logic              r_clr_busy;
    logic [TBL_AW-1:0] r_clr_addr;

    // parser
    logic       r_in_value, n_in_value;
    logic [9:0] r_chan_acc, n_chan_acc;
    logic [7:0] r_val_acc, n_val_acc;

    // sequencer
    logic [2:0] r_phase, n_phase;
    logic [9:0] r_tick, n_tick;
    logic [3:0] r_bit, n_bit;
    logic [9:0] r_slot, n_slot;
    logic [7:0] r_shift, n_shift;
    logic       r_shift_pend, n_shift_pend;

    // output register
    logic       r_out_valid;
    logic       r_out_level;
    logic [2:0] r_out_phase;
    logic [9:0] r_out_slot;

    logic              w_in_fire;
    logic              w_is_tick;
    logic [7:0]        w_sh_eff;
    logic [9:0]        w_slot_lim;
    logic [9:0]        w_break_min, w_mab_min, w_bit_min;
    logic              w_wr_en;
    logic [TBL_AW-1:0] w_wr_addr;
    logic              w_rd_en;
    logic [TBL_AW-1:0] w_rd_addr;
    logic              w_rep_level;
    logic [2:0]        w_rep_phase;
    logic [9:0]        w_rep_slot;

    assign o_in_ready  = !r_clr_busy && (!r_out_valid || i_out_ready);
    assign w_in_fire   = i_in_valid && o_in_ready;
    assign w_is_tick   = (i_op == OP_TICK);
    assign w_sh_eff    = r_shift_pend ? r_tbl_q : r_shift;
    assign w_slot_lim  = (r_slot_count > CH_MAX) ? CH_MAX : r_slot_count;
    assign w_break_min = (r_break_time == 10'd0) ? 10'd1 : r_break_time;
    assign w_mab_min   = (r_mab_time == 10'd0) ? 10'd1 : r_mab_time;
    assign w_bit_min   = (r_bit_time == 5'd0) ? 10'd1 : {5'd0, r_bit_time};

    // command parser
    always_comb begin
        logic [13:0] prod;
        logic [3:0]  dig;
        logic        commit;
        prod       = '0;
        dig        = 4'(i_text_byte - CH_ZERO);
        commit     = 1'b0;
        n_in_value = r_in_value;
        n_chan_acc = r_chan_acc;
        n_val_acc  = r_val_acc;
        if (w_in_fire && i_op == OP_CHAR) begin
            if (i_text_byte >= CH_ZERO && i_text_byte <= CH_NINE) begin
                if (r_in_value) begin
                    n_val_acc = 8'(r_val_acc * 8'd10 + {4'd0, dig});
                end else begin
                    prod = {4'd0, r_chan_acc} * 14'd10 + {10'd0, dig};
                    n_chan_acc = (prod > {4'd0, CHAN_SAT}) ? CHAN_SAT : prod[9:0];
                end
            end else if (i_text_byte == CH_COLON) begin
                n_in_value = 1'b1;
            end else if (i_text_byte == CH_COMMA) begin
                commit = 1'b1;
            end
        end else if (w_in_fire && i_op == OP_EOM) begin
            commit = 1'b1;
        end
        w_wr_en   = 1'b0;
        w_wr_addr = TBL_AW'(r_chan_acc - 10'd1);
        if (commit) begin
            w_wr_en    = (r_chan_acc >= 10'd1) && (r_chan_acc <= CH_MAX);
            n_chan_acc = '0;
            n_val_acc  = '0;
            n_in_value = 1'b0;
        end
    end

    // frame sequencer
    always_comb begin
        logic [2:0] ph;
        logic [9:0] tk;
        logic [3:0] bp;
        logic [9:0] sc;
        logic [7:0] sh;
        ph = r_phase;
        tk = r_tick;
        bp = r_bit;
        sc = r_slot;
        sh = w_sh_eff;
        w_rd_en   = 1'b0;
        w_rd_addr = '0;

        // settle the state against the current register values
        if (ph > PH_POST) begin
            ph = (r_pre_idle == 10'd0) ? PH_BREAK : PH_PRE;
            tk = '0;
        end
        if (ph == PH_PRE && r_pre_idle == 10'd0) begin
            ph = PH_BREAK;
            tk = '0;
        end
        if (ph == PH_POST && r_post_idle == 10'd0) begin
            ph = (r_pre_idle == 10'd0) ? PH_BREAK : PH_PRE;
            tk = '0;
        end
        if (ph == PH_SLOTS && sc > w_slot_lim) begin
            ph = PH_POST;
            tk = '0;
            sc = '0;
            bp = '0;
            if (r_post_idle == 10'd0) begin
                ph = (r_pre_idle == 10'd0) ? PH_BREAK : PH_PRE;
            end
        end

        if (!w_is_tick) begin
            ph = r_phase;
            tk = r_tick;
            bp = r_bit;
            sc = r_slot;
        end

        w_rep_level = 1'b1;
        w_rep_slot  = '0;
        w_rep_phase = ph;
        if (ph == PH_BREAK) begin
            w_rep_level = 1'b0;
        end else if (ph == PH_SLOTS) begin
            w_rep_slot = sc;
            if (bp == 4'd0) begin
                w_rep_level = 1'b0;
            end else if (bp <= 4'd8) begin
                w_rep_level = sh[0];
            end
        end

        // advance one tick
        tk = tk + 10'd1;
        unique case (ph)
            PH_PRE: begin
                if (tk >= r_pre_idle) begin
                    ph = PH_BREAK;
                    tk = '0;
                end
            end
            PH_BREAK: begin
                if (tk >= w_break_min) begin
                    ph = PH_MAB;
                    tk = '0;
                end
            end
            PH_MAB: begin
                if (tk >= w_mab_min) begin
                    ph = PH_SLOTS;
                    sc = '0;
                    bp = '0;
                    tk = '0;
                    sh = '0;
                end
            end
            PH_SLOTS: begin
                if (tk >= w_bit_min) begin
                    tk = '0;
                    if (bp >= 4'd1 && bp <= 4'd8) begin
                        sh = {1'b0, sh[7:1]};
                    end
                    bp = bp + 4'd1;
                    if (bp >= BITS_SLOT) begin
                        sc = sc + 10'd1;
                        if (sc > w_slot_lim) begin
                            ph = PH_POST;
                            tk = '0;
                            sc = '0;
                            bp = '0;
                            if (r_post_idle == 10'd0) begin
                                ph = (r_pre_idle == 10'd0) ? PH_BREAK : PH_PRE;
                            end
                        end else begin
                            bp = '0;
                            if (sc >= 10'd1 && sc <= CH_MAX) begin
                                w_rd_en   = 1'b1;
                                w_rd_addr = TBL_AW'(sc - 10'd1);
                            end else begin
                                sh = '0;
                            end
                        end
                    end
                end
            end
            default: begin
                if (tk >= r_post_idle) begin
                    ph = (r_pre_idle == 10'd0) ? PH_BREAK : PH_PRE;
                    tk = '0;
                end
            end
        endcase

        n_phase      = r_phase;
        n_tick       = r_tick;
        n_bit        = r_bit;
        n_slot       = r_slot;
        n_shift      = w_sh_eff;
        n_shift_pend = 1'b0;
        if (w_in_fire && w_is_tick) begin
            n_phase      = ph;
            n_tick       = tk;
            n_bit        = bp;
            n_slot       = sc;
            n_shift      = sh;
            n_shift_pend = w_rd_en;
        end else begin
            w_rd_en = 1'b0;
        end
    end

    // channel table RAM
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_tbl[r_clr_addr] <= '0;
        end else if (w_wr_en) begin
            r_tbl[w_wr_addr] <= r_val_acc;
        end
        if (w_rd_en) begin
            r_tbl_q <= r_tbl[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + TBL_AW'(1);
            if (r_clr_addr == CLR_LAST) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_break_time <= RST_BREAK;
            r_mab_time   <= RST_MAB;
            r_pre_idle   <= RST_PRE_IDLE;
            r_post_idle  <= RST_POST_IDLE;
            r_bit_time   <= RST_BIT_TIME;
            r_slot_count <= RST_SLOTS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_BREAK:     r_break_time <= i_cfg_data;
                REG_MAB:       r_mab_time   <= i_cfg_data;
                REG_PRE_IDLE:  r_pre_idle   <= i_cfg_data;
                REG_POST_IDLE: r_post_idle  <= i_cfg_data;
                REG_BIT_TIME:  r_bit_time   <= i_cfg_data[4:0];
                REG_SLOTS:     r_slot_count <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_value   <= 1'b0;
            r_chan_acc   <= '0;
            r_val_acc    <= '0;
            r_phase      <= PH_PRE;
            r_tick       <= '0;
            r_bit        <= '0;
            r_slot       <= '0;
            r_shift      <= '0;
            r_shift_pend <= 1'b0;
        end else begin
            r_in_value   <= n_in_value;
            r_chan_acc   <= n_chan_acc;
            r_val_acc    <= n_val_acc;
            r_phase      <= n_phase;
            r_tick       <= n_tick;
            r_bit        <= n_bit;
            r_slot       <= n_slot;
            r_shift      <= n_shift;
            r_shift_pend <= n_shift_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_out_level <= w_rep_level;
            r_out_phase <= w_rep_phase;
            r_out_slot  <= w_rep_slot;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_line_level  = r_out_level;
    assign o_frame_phase = r_out_phase;
    assign o_slot_number = r_out_slot;

    a_pend_after_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_shift_pend |-> ($past(w_in_fire) && $past(i_op) == OP_TICK))
        else $error("slot byte pending without a preceding tick");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire |=> o_out_valid)
        else $error("accepted beat produced no result");

    a_break_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_phase == PH_BREAK) |-> !o_line_level)
        else $error("line high during break");

    a_slot_outside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_phase != PH_SLOTS) |-> (o_slot_number == 10'd0))
        else $error("slot number outside slots phase");

    a_no_take_while_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !(w_wr_en || w_rd_en))
        else $error("table access during clearing pass");

endmodule

/* sim/tb.sv */
// Self-checking testbench for the DMX512 frame transmitter.
`timescale 1ns / 1ps

module tb;
    import dmx_tx_pkg::*;

    localparam logic [1:0] OP_NONE = 2'd3;
    localparam logic [CFG_IW-1:0] REG_NONE = 3'd7;
    localparam int unsigned CYCLE_LIMIT = 400000;

    typedef struct {
        logic [9:0] brk;
        logic [9:0] mab;
        logic [9:0] pre;
        logic [9:0] post;
        logic [4:0] bitt;
        logic [9:0] slots;
    } t_frame_cfg;

    typedef struct {
        logic       line;
        logic [2:0] phase;
        logic [9:0] slot;
    } t_line_beat;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [CFG_IW-1:0] i_cfg_index = '0;
    logic [CFG_DW-1:0] i_cfg_data = '0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic [1:0]        i_op = OP_TICK;
    logic [7:0]        i_text_byte = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic              o_line_level;
    logic [2:0]        o_frame_phase;
    logic [9:0]        o_slot_number;

    dmx512_frame_transmitter i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_op          (i_op),
        .i_text_byte   (i_text_byte),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_line_level  (o_line_level),
        .o_frame_phase (o_frame_phase),
        .o_slot_number (o_slot_number)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Predictor state
    logic [9:0]  cfg_break, cfg_mab, cfg_pre, cfg_post, cfg_slots;
    logic [4:0]  cfg_bit;
    logic [7:0]  lvl_tbl [CHANNELS];
    bit          in_value;
    int unsigned chan_acc, val_acc;
    logic [2:0]  ph;
    int unsigned tick_cnt, bit_pos, slot_cnt;
    logic [7:0]  shreg;

    t_line_beat  line_exp_q [$];
    int unsigned beats_sent, results_seen, settings_used, err_cnt, cycles;
    bit          src_gaps, sink_stalls;
    int unsigned hold_cnt;

    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int unsigned min_one(int unsigned v);
        return (v == 0) ? 1 : v;
    endfunction

    function automatic int unsigned slot_cap();
        return (cfg_slots > CHANNELS) ? CHANNELS : cfg_slots;
    endfunction

    function automatic void reset_model();
        cfg_break = RST_BREAK;
        cfg_mab   = RST_MAB;
        cfg_pre   = RST_PRE_IDLE;
        cfg_post  = RST_POST_IDLE;
        cfg_bit   = RST_BIT_TIME;
        cfg_slots = RST_SLOTS;
        foreach (lvl_tbl[i]) lvl_tbl[i] = '0;
        in_value = 0;
        chan_acc = 0;
        val_acc  = 0;
        ph       = PH_PRE;
        tick_cnt = 0;
        bit_pos  = 0;
        slot_cnt = 0;
        shreg    = '0;
    endfunction

    function automatic void latch_slot();
        bit_pos  = 0;
        tick_cnt = 0;
        if (slot_cnt == 0 || slot_cnt > CHANNELS) shreg = '0;
        else shreg = lvl_tbl[slot_cnt-1];
    endfunction

    function automatic void go_break();
        ph = PH_BREAK;
        tick_cnt = 0;
    endfunction

    function automatic void go_pre();
        ph = PH_PRE;
        tick_cnt = 0;
        if (cfg_pre == 0) go_break();
    endfunction

    function automatic void go_post();
        ph = PH_POST;
        tick_cnt = 0;
        slot_cnt = 0;
        bit_pos = 0;
        if (cfg_post == 0) go_pre();
    endfunction

    function automatic void go_slots();
        ph = PH_SLOTS;
        slot_cnt = 0;
        latch_slot();
    endfunction

    function automatic void commit_pair();
        if (chan_acc >= 1 && chan_acc <= CHANNELS) lvl_tbl[chan_acc-1] = val_acc[7:0];
        chan_acc = 0;
        val_acc  = 0;
        in_value = 0;
    endfunction

    function automatic void parse_char(logic [7:0] c);
        int unsigned d, n;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = c - CH_ZERO;
            if (in_value) begin
                val_acc = (val_acc * 10 + d) & 8'hFF;
            end else begin
                n = chan_acc * 10 + d;
                chan_acc = (n > CHAN_SAT) ? CHAN_SAT : n;
            end
        end else if (c == CH_COLON) begin
            in_value = 1;
        end else if (c == CH_COMMA) begin
            commit_pair();
        end
    endfunction

    // registers may have shrunk under a running frame
    function automatic void settle_phase();
        if (ph == PH_PRE && cfg_pre == 0) go_break();
        if (ph == PH_POST && cfg_post == 0) go_pre();
        if (ph == PH_SLOTS && slot_cnt > slot_cap()) go_post();
    endfunction

    function automatic void tick_advance();
        tick_cnt = (tick_cnt + 1) & 10'h3FF;
        case (ph)
            PH_PRE: begin
                if (tick_cnt >= cfg_pre) go_break();
            end
            PH_BREAK: begin
                if (tick_cnt >= min_one(cfg_break)) begin
                    ph = PH_MAB;
                    tick_cnt = 0;
                end
            end
            PH_MAB: begin
                if (tick_cnt >= min_one(cfg_mab)) go_slots();
            end
            PH_SLOTS: begin
                if (tick_cnt >= min_one(cfg_bit)) begin
                    tick_cnt = 0;
                    if (bit_pos >= 1 && bit_pos <= 8) shreg = shreg >> 1;
                    bit_pos++;
                    if (bit_pos >= BITS_SLOT) begin
                        slot_cnt++;
                        if (slot_cnt > slot_cap()) go_post();
                        else latch_slot();
                    end
                end
            end
            default: begin
                if (tick_cnt >= cfg_post) go_pre();
            end
        endcase
    endfunction

    function automatic t_line_beat line_now();
        t_line_beat r;
        r.line  = 1'b1;
        r.phase = ph;
        r.slot  = '0;
        if (ph == PH_BREAK) begin
            r.line = 1'b0;
        end else if (ph == PH_SLOTS) begin
            r.slot = slot_cnt[9:0];
            if (bit_pos == 0) r.line = 1'b0;
            else if (bit_pos <= 8) r.line = shreg[0];
        end
        return r;
    endfunction

    function automatic t_line_beat predict_line(logic [1:0] op, logic [7:0] c);
        t_line_beat r;
        case (op)
            OP_CHAR: begin
                parse_char(c);
                r = line_now();
            end
            OP_EOM: begin
                commit_pair();
                r = line_now();
            end
            OP_TICK: begin
                settle_phase();
                r = line_now();
                tick_advance();
            end
            default: r = line_now();
        endcase
        return r;
    endfunction

    function automatic void note_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
        case (idx)
            REG_BREAK:     cfg_break = val;
            REG_MAB:       cfg_mab   = val;
            REG_PRE_IDLE:  cfg_pre   = val;
            REG_POST_IDLE: cfg_post  = val;
            REG_BIT_TIME:  cfg_bit   = val[4:0];
            REG_SLOTS:     cfg_slots = val;
            default: ;
        endcase
    endfunction

    task automatic send_beat(input logic [1:0] op, input logic [7:0] c);
        int unsigned gap;
        i_in_valid  <= 1'b1;
        i_op        <= op;
        i_text_byte <= c;
        do @(posedge i_clk); while (!o_in_ready);
        line_exp_q.push_back(predict_line(op, c));
        beats_sent++;
        gap = src_gaps ? idle_len() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_beat(OP_CHAR, s[i]);
    endtask

    task automatic quiesce();
        i_in_valid <= 1'b0;
        while (line_exp_q.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic load_settings(input t_frame_cfg s);
        logic [CFG_IW-1:0] idx [7];
        logic [CFG_DW-1:0] val [7];
        quiesce();
        idx = '{REG_BREAK, REG_MAB, REG_PRE_IDLE, REG_POST_IDLE, REG_BIT_TIME,
                REG_SLOTS, REG_NONE};
        val = '{s.brk, s.mab, s.pre, s.post, {5'd0, s.bitt}, s.slots,
                10'($urandom_range(0, 1023))};
        for (int i = 0; i < 7; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idx[i];
            i_cfg_data  <= val[i];
            @(posedge i_clk);
            note_reg(idx[i], val[i]);
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        settings_used++;
    endtask

    task automatic send_pair();
        int unsigned chan, value, r;
        r = $urandom_range(0, 9);
        if (r < 6) chan = $urandom_range(1, 8);
        else if (r < 8) chan = $urandom_range(1, CHANNELS);
        else if (r == 8) chan = $urandom_range(0, 1) ? 0 : $urandom_range(CHANNELS + 1, 1023);
        else chan = $urandom_range(1024, 99999);
        value = ($urandom_range(0, 4) == 0) ? $urandom_range(256, 999) : $urandom_range(0, 255);
        send_text($sformatf("%0d:%0d", chan, value));
        if ($urandom_range(0, 1)) send_beat(OP_EOM, 8'($urandom));
        else send_beat(OP_CHAR, CH_COMMA);
    endtask

    task automatic send_noise();
        case ($urandom_range(0, 5))
            0: send_beat(OP_CHAR, 8'($urandom));
            1: send_beat(OP_CHAR, 8'($urandom_range(CH_ZERO, CH_NINE)));
            2: send_beat(OP_CHAR, CH_COLON);
            3: send_beat(OP_CHAR, CH_COMMA);
            4: send_beat(OP_EOM, 8'($urandom));
            default: send_beat(OP_NONE, 8'($urandom));
        endcase
    endtask

    task automatic run_segment(input t_frame_cfg s, input int unsigned n);
        int unsigned stop_at, r;
        load_settings(s);
        src_gaps    = ($urandom_range(0, 3) != 0);
        sink_stalls = ($urandom_range(0, 3) != 0);
        stop_at = beats_sent + n;
        while (beats_sent < stop_at) begin
            r = $urandom_range(0, 99);
            if (r < 55) repeat ($urandom_range(1, 12)) send_beat(OP_TICK, 8'($urandom));
            else if (r < 88) send_pair();
            else send_noise();
        end
    endtask

    task automatic test_command_parsing();
        src_gaps    = 1;
        sink_stalls = 1;
        send_text("1:12,2:45");
        send_beat(OP_EOM, 8'h00);
        send_text("512::300,9999:7");
        send_beat(OP_NONE, 8'hFF);
        send_beat(OP_EOM, 8'hFF);
    endtask

    task automatic test_register_extremes();
        run_segment('{10'd0, 10'd0, 10'd0, 10'd0, 5'd0, 10'd0}, 72);
        run_segment('{10'd1023, 10'd1023, 10'd1023, 10'd1023, 5'd31, 10'd1023}, 72);
        run_segment('{10'd1, 10'd1, 10'd0, 10'd1, 5'd1, 10'd2}, 72);
        run_segment('{10'd1, 10'd1, 10'd0, 10'd0, 5'd16, 10'd512}, 72);
    endtask

    task automatic test_random_frames();
        t_frame_cfg s;
        repeat (6) begin
            s.brk   = ($urandom_range(0, 7) == 0) ? 10'd0 : 10'($urandom_range(1, 4));
            s.mab   = 10'($urandom_range(0, 3));
            s.pre   = 10'($urandom_range(0, 3));
            s.post  = 10'($urandom_range(0, 3));
            s.bitt  = 5'($urandom_range(0, 3));
            s.slots = ($urandom_range(0, 7) == 0) ? 10'($urandom_range(0, 1) * 512)
                                                  : 10'($urandom_range(1, 6));
            run_segment(s, 72);
        end
    endtask

    // receiver with random back-pressure
    always @(posedge i_clk) begin
        if (hold_cnt > 0) begin
            hold_cnt--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            if (sink_stalls && $urandom_range(0, 4) == 0) hold_cnt = 1 + idle_len();
        end
    end

    always @(posedge i_clk) begin
        t_line_beat e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (line_exp_q.size() == 0) begin
                $error("result beat with nothing expected");
                err_cnt++;
            end else begin
                e = line_exp_q.pop_front();
                if (o_line_level !== e.line) begin
                    $error("line_level: expected %0d, got %0d", e.line, o_line_level);
                    err_cnt++;
                end
                if (o_frame_phase !== e.phase) begin
                    $error("frame_phase: expected %0d, got %0d", e.phase, o_frame_phase);
                    err_cnt++;
                end
                if (o_slot_number !== e.slot) begin
                    $error("slot_number: expected %0d, got %0d", e.slot, o_slot_number);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $error("timeout after %0d cycles", cycles);
            $display("tb: errors");
            $finish;
        end
    end

    initial begin
        reset_model();
        src_gaps = 0;
        sink_stalls = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_command_parsing();
        test_register_extremes();
        test_random_frames();

        quiesce();
        repeat (8) @(posedge i_clk);
        if (line_exp_q.size() != 0) begin
            $error("%0d result beats never arrived", line_exp_q.size());
            err_cnt++;
        end
        $display("summary: %0d beats sent, %0d results compared, %0d register settings",
                 beats_sent, results_seen, settings_used);
        $display("summary: %0d mismatches over %0d cycles", err_cnt, cycles);
        if (err_cnt == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

/* files.f */
hw/rtl/dmx_tx_pkg.sv
hw/rtl/dmx512_frame_transmitter.sv
sim/tb.sv
